@@ rtl/core/bpa_pkg.sv @@
// Types and constants shared by the bump page allocator files.
package bpa_pkg;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned PAGES_W    = 52;
  localparam int unsigned TYPE_W     = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Item opcodes
  localparam logic [OP_W-1:0] OP_REGION = 2'd0;
  localparam logic [OP_W-1:0] OP_BREAK  = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVAIL     = 1'd1;

  // Reset values
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST  = 32'h0010_0000;
  localparam logic [CFG_DATA_W-1:0] AVAIL_RST      = 32'h0000_0001;
  localparam logic [ADDR_W-1:0]     HEAP_START_RST = 64'h0000_0000_0010_0000;
  localparam logic [ADDR_W-1:0]     HEAP_END_RST   = 64'h0000_0000_0020_0000;
  localparam logic [ADDR_W-1:0]     HEAP_SPAN_RST  = 64'h0000_0000_0010_0000;

  // Item as held in the input register, with the region arithmetic done early
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               region_ok;
    logic [ADDR_W-1:0]  region_start;
    logic [ADDR_W-1:0]  region_end;
    logic [ADDR_W-1:0]  region_span;
    logic [ADDR_W-1:0]  new_start;
    logic [ADDR_W-1:0]  new_end;
    logic [PAGES_W-1:0] page_count;
    logic [ADDR_W-1:0]  alloc_bytes;
  } bpa_item_t;

  // Input register status seen by the heap stage
  typedef struct packed {
    logic valid;
  } bpa_stage_t;

endpackage

@@ rtl/core/bpa_ifs.sv @@
// Channel interfaces: input items, result items and configuration writes.
interface bpa_in_if
  import bpa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [ADDR_W-1:0]  region_base;
  logic [ADDR_W-1:0]  region_length;
  logic [TYPE_W-1:0]  region_type;
  logic [ADDR_W-1:0]  new_start;
  logic [ADDR_W-1:0]  new_end;
  logic [PAGES_W-1:0] page_count;

  modport source(output valid, op, region_base, region_length, region_type, new_start,
                 new_end, page_count, input ready);
  modport sink(input valid, op, region_base, region_length, region_type, new_start,
               new_end, page_count, output ready);
endinterface

interface bpa_out_if
  import bpa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [ADDR_W-1:0]  block_address;
  logic [PAGES_W-1:0] pages_free;

  modport source(output valid, granted, block_address, pages_free, input ready);
  modport sink(input valid, granted, block_address, pages_free, output ready);
endinterface

interface bpa_cfg_if
  import bpa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/bpa_cfg_regs.sv @@
// Configuration registers: high-memory threshold and usable type code.
module bpa_cfg_regs
  import bpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bpa_cfg_if.sink               cfg_ch,
  output logic [CFG_DATA_W-1:0] threshold,
  output logic [CFG_DATA_W-1:0] avail_type
);

  logic [CFG_DATA_W-1:0] threshold_r;
  logic [CFG_DATA_W-1:0] avail_type_r;

  assign cfg_ch.ready = 1'b1;
  assign threshold    = threshold_r;
  assign avail_type   = avail_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      avail_type_r <= AVAIL_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_THRESHOLD: threshold_r  <= cfg_ch.data;
        CFG_AVAIL:     avail_type_r <= cfg_ch.data;
        default:       ;
      endcase
    end
  end

endmodule

@@ rtl/core/bpa_front.sv @@
// Input register: takes an item and does the state-free region arithmetic.
module bpa_front
  import bpa_pkg::*;
#(
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bpa_in_if.sink                in_ch,
  input  logic [CFG_DATA_W-1:0] threshold,
  input  logic [CFG_DATA_W-1:0] avail_type,
  input  logic                  advance,
  output bpa_stage_t            stage,
  output bpa_item_t             item
);

  localparam logic [ADDR_W-1:0] PAGE_MASK = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);

  logic            valid_r;
  logic            valid_nxt;
  bpa_item_t       item_r;
  bpa_item_t       item_nxt;
  logic [ADDR_W-1:0] aligned;
  logic [ADDR_W-1:0] end_addr;
  logic [ADDR_W:0]   diff;
  logic              take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    aligned  = (in_ch.region_base + PAGE_MASK) & ~PAGE_MASK;
    end_addr = in_ch.region_base + in_ch.region_length;
    // borrow clear and nonzero: rounded base lies below the end
    diff     = {1'b0, end_addr} - {1'b0, aligned};

    item_nxt.op           = in_ch.op;
    item_nxt.region_ok    = (in_ch.region_type == avail_type)
                         && (in_ch.region_base >= {{(ADDR_W-CFG_DATA_W){1'b0}}, threshold})
                         && (in_ch.region_length != '0)
                         && !diff[ADDR_W] && (diff[ADDR_W-1:0] != '0);
    item_nxt.region_start = aligned;
    item_nxt.region_end   = end_addr;
    item_nxt.region_span  = diff[ADDR_W-1:0];
    item_nxt.new_start    = in_ch.new_start;
    item_nxt.new_end      = in_ch.new_end;
    item_nxt.page_count   = in_ch.page_count;
    item_nxt.alloc_bytes  = ADDR_W'(in_ch.page_count) << PAGE_SHIFT;

    valid_nxt = take ? 1'b1 : (advance ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign stage.valid = valid_r;
  assign item        = item_r;

endmodule

@@ rtl/core/bpa_heap.sv @@
// Heap state, per-item update and result register.
module bpa_heap
  import bpa_pkg::*;
#(
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  bpa_stage_t stage,
  input  bpa_item_t  item,
  output logic       advance,
  bpa_out_if.source  out_ch
);

  logic [ADDR_W-1:0]  start_r, start_nxt;
  logic [ADDR_W-1:0]  end_r, end_nxt;
  logic [ADDR_W-1:0]  span_r, span_nxt;
  logic [PAGES_W-1:0] free_r, free_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               granted_r, granted_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [PAGES_W-1:0] pages_r;
  logic [ADDR_W-1:0]  brk_start;
  logic [ADDR_W-1:0]  brk_end;
  logic [ADDR_W:0]    brk_diff;
  logic [ADDR_W-1:0]  pages_full;
  logic               fire;

  assign advance = !out_valid_r || out_ch.ready;
  assign fire    = stage.valid && advance;

  always_comb begin
    start_nxt   = start_r;
    end_nxt     = end_r;
    span_nxt    = span_r;
    granted_nxt = 1'b0;
    addr_nxt    = '0;

    brk_start = (item.new_start > start_r) ? item.new_start : start_r;
    brk_end   = ((item.new_end != '0) && (item.new_end < end_r)) ? item.new_end : end_r;
    brk_diff  = {1'b0, brk_end} - {1'b0, brk_start};

    case (item.op)
      OP_REGION: begin
        if (item.region_ok && (item.region_span > span_r)) begin
          start_nxt = item.region_start;
          end_nxt   = item.region_end;
          span_nxt  = item.region_span;
        end
      end
      OP_BREAK: begin
        start_nxt = brk_start;
        end_nxt   = brk_end;
        span_nxt  = brk_diff[ADDR_W] ? '0 : brk_diff[ADDR_W-1:0];
      end
      OP_ALLOC: begin
        if ((item.page_count != '0) && (item.page_count <= free_r)) begin
          granted_nxt = 1'b1;
          addr_nxt    = start_r;
          start_nxt   = start_r + item.alloc_bytes;
          // grant fits inside the span, so no underflow here
          span_nxt    = span_r - item.alloc_bytes;
        end
      end
      default: ;
    endcase

    pages_full = span_nxt >> PAGE_SHIFT;
    free_nxt   = (|pages_full[ADDR_W-1:PAGES_W]) ? '1 : pages_full[PAGES_W-1:0];

    out_valid_nxt = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= HEAP_START_RST;
      end_r       <= HEAP_END_RST;
      span_r      <= HEAP_SPAN_RST;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        start_r <= start_nxt;
        end_r   <= end_nxt;
        span_r  <= span_nxt;
        free_r  <= free_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      granted_r <= granted_nxt;
      addr_r    <= addr_nxt;
      pages_r   <= free_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.granted       = granted_r;
  assign out_ch.block_address = addr_r;
  assign out_ch.pages_free    = pages_r;

endmodule

@@ rtl/core/bump_page_allocator_core.sv @@
// Top level of the bump page allocator.
// The block keeps a heap span [start, end) and a free page count, and takes
// one item per clock: a memory-map region offer, a break update or a page
// allocation. Every item gives exactly one result item carrying the grant
// flag, the granted block address (zero when refused) and the free page
// count after the item. An accepted item is held first in the input
// register, where the region rounding and length arithmetic are done, and
// the heap stage then updates the state and loads the result register that
// drives out_ch. Sustained rate is one item per cycle; it drops only while
// the result side stalls, and in_ch.ready then follows out_ch.ready
// combinationally once both stages hold an item. The heap stage keeps the
// span (end minus start) in a register of its own so an item never needs
// more than one wide subtract on the state. Configuration writes are taken
// at any time with ready held high and are meant to land while the block
// is idle. Page size is 2**PAGE_SHIFT bytes.
module bump_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  bpa_in_if.sink    in_ch,
  bpa_out_if.source out_ch,
  bpa_cfg_if.sink   cfg_ch
);

  logic [CFG_DATA_W-1:0] threshold;
  logic [CFG_DATA_W-1:0] avail_type;
  logic                  advance;
  bpa_stage_t            stage;
  bpa_item_t             item;

  // configuration registers
  bpa_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .threshold  (threshold),
    .avail_type (avail_type)
  );

  // input register with region pre-computation
  bpa_front #(
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .threshold  (threshold),
    .avail_type (avail_type),
    .advance    (advance),
    .stage      (stage),
    .item       (item)
  );

  // heap state and result register
  bpa_heap #(
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_heap (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .item    (item),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule
